// ===== hw/rtl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared widths, operation and status codes, and the command and status
// structs that join the page walk controller and datapath.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int DIR_ENTRIES     = 1024;
   localparam int DIR_AW          = 10;
   localparam int TBL_AW          = 10;
   localparam int OFF_W           = 12;
   localparam int ADDR_W          = 32;
   localparam int FRAME_W         = ADDR_W - OFF_W;
   localparam int NUM_TABLES_DEF  = 16;

   localparam int DIR_LSB         = OFF_W + TBL_AW;   // 22
   localparam int TBL_LSB         = OFF_W;            // 12

   localparam logic [1:0] OP_MAP    = 2'd0;
   localparam logic [1:0] OP_UNMAP  = 2'd1;
   localparam logic [1:0] OP_XLATE  = 2'd2;

   localparam logic [2:0] ST_OK             = 3'd0;
   localparam logic [2:0] ST_NOT_MAPPED     = 3'd1;
   localparam logic [2:0] ST_ALREADY        = 3'd2;
   localparam logic [2:0] ST_NO_TABLE       = 3'd3;
   localparam logic [2:0] ST_UNMAP_NO_TABLE = 3'd4;

   typedef struct packed {
      logic       load;         // latch request, read directory
      logic       clr_step;     // clearing pass write
      logic       alloc;        // bind next free table to directory slot
      logic       pg_rd;        // read page entry
      logic       pg_unmap_wr;  // zero page entry at lookup address
      logic       pg_map_wr;    // write new entry at read address
      logic       finish;       // load result register
      logic       xlate_ok;     // result carries frame plus offset
      logic [2:0] status;
   } ptw_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       dir_valid;
      logic       tables_full;
      logic       pg_nonzero;
      logic       clr_last;
      logic       out_free;
   } ptw_stat_type;

endpackage

// ===== hw/rtl/ptw_datapath.sv =====
// ----------------------------------------------------------------------------
// ptw_datapath
// Request registers, directory and page entry memories, table allocator,
// clearing counter and result register.
// ----------------------------------------------------------------------------
module ptw_datapath #(
   parameter int NUM_TABLES = ptw_pkg::NUM_TABLES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ptw_pkg::ptw_cmd_type       cmd,
   output ptw_pkg::ptw_stat_type      stat,
   input  logic [1:0]                 req_opcode,
   input  logic [ptw_pkg::ADDR_W-1:0] req_virt_addr,
   input  logic [ptw_pkg::ADDR_W-1:0] req_phys_addr,
   input  logic [ptw_pkg::OFF_W-1:0]  req_page_flags,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [ptw_pkg::ADDR_W-1:0] rsp_phys_result,
   output logic [2:0]                 rsp_status
);
   import ptw_pkg::*;

   localparam int SLOT_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int NF_W       = $clog2(NUM_TABLES + 1);
   localparam int PAGE_DEPTH = NUM_TABLES * (2 ** TBL_AW);
   localparam int PAGE_AW    = SLOT_W + TBL_AW;

   // directory entry: valid bit above table slot
   logic [SLOT_W:0]        dir_mem [DIR_ENTRIES];
   logic [ADDR_W-1:0]      page_mem [PAGE_DEPTH];

   logic [1:0]             op_ff;
   logic [ADDR_W-1:0]      va_ff;
   logic [ADDR_W-1:0]      pa_ff;
   logic [OFF_W-1:0]       fl_ff;
   logic [SLOT_W:0]        dir_q_ff;
   logic [ADDR_W-1:0]      pg_q_ff;
   logic [PAGE_AW-1:0]     pg_addr_ff;
   logic [NF_W-1:0]        next_free_ff;
   logic [NF_W-1:0]        next_free_in;
   logic [PAGE_AW-1:0]     clr_cnt_ff;
   logic [PAGE_AW-1:0]     clr_cnt_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_phys_ff;
   logic [2:0]             rsp_status_ff;

   logic [SLOT_W-1:0]      slot_c;
   logic [PAGE_AW-1:0]     pg_addr_c;
   logic                   dir_we;
   logic [DIR_AW-1:0]      dir_wa;
   logic [SLOT_W:0]        dir_wd;
   logic                   pg_we;
   logic [PAGE_AW-1:0]     pg_wa;
   logic [ADDR_W-1:0]      pg_wd;
   logic                   out_free;

   // an empty slot takes the table that is about to be allocated
   assign slot_c    = dir_q_ff[SLOT_W] ? dir_q_ff[SLOT_W-1:0] : next_free_ff[SLOT_W-1:0];
   assign pg_addr_c = {slot_c, va_ff[DIR_LSB-1:TBL_LSB]};
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      dir_we = cmd.clr_step || cmd.alloc;
      if (cmd.clr_step) begin
         dir_wa = clr_cnt_ff[DIR_AW-1:0];
         dir_wd = '0;
      end else begin
         dir_wa = va_ff[ADDR_W-1:DIR_LSB];
         dir_wd = {1'b1, next_free_ff[SLOT_W-1:0]};
      end
   end

   always_comb begin
      pg_we = cmd.clr_step || cmd.pg_unmap_wr || cmd.pg_map_wr;
      priority if (cmd.clr_step) begin
         pg_wa = clr_cnt_ff;
         pg_wd = '0;
      end else if (cmd.pg_unmap_wr) begin
         pg_wa = pg_addr_c;
         pg_wd = '0;
      end else begin
         pg_wa = pg_addr_ff;
         pg_wd = {pa_ff[ADDR_W-1:OFF_W], fl_ff};
      end
   end

   always_comb begin
      next_free_in = next_free_ff;
      if (cmd.alloc) begin
         next_free_in = next_free_ff + NF_W'(1);
      end
      clr_cnt_in = clr_cnt_ff;
      if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + PAGE_AW'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         next_free_ff <= next_free_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         va_ff    <= req_virt_addr;
         pa_ff    <= req_phys_addr;
         fl_ff    <= req_page_flags;
         dir_q_ff <= dir_mem[req_virt_addr[ADDR_W-1:DIR_LSB]];
      end
      if (dir_we) begin
         dir_mem[dir_wa] <= dir_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pg_rd) begin
         pg_q_ff    <= page_mem[pg_addr_c];
         pg_addr_ff <= pg_addr_c;
      end
      if (pg_we) begin
         page_mem[pg_wa] <= pg_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= cmd.status;
         rsp_phys_ff   <= cmd.xlate_ok ? {pg_q_ff[ADDR_W-1:OFF_W], va_ff[OFF_W-1:0]} : '0;
      end
   end

   assign stat.op          = op_ff;
   assign stat.dir_valid   = dir_q_ff[SLOT_W];
   assign stat.tables_full = (next_free_ff == NF_W'(NUM_TABLES));
   assign stat.pg_nonzero  = (pg_q_ff != '0);
   assign stat.clr_last    = (clr_cnt_ff == PAGE_AW'(PAGE_DEPTH - 1));
   assign stat.out_free    = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phys_result = rsp_phys_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== hw/rtl/ptw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptw_ctrl
// Sequencer for the page walk: clearing pass, accept, directory lookup,
// page entry check and write-back.
// ----------------------------------------------------------------------------
module ptw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ptw_pkg::ptw_stat_type stat,
   output ptw_pkg::ptw_cmd_type  cmd
);
   import ptw_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_PAGE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            unique case (stat.op)
               OP_MAP: begin
                  if (stat.dir_valid) begin
                     cmd.pg_rd = 1'b1;
                     state_in  = S_PAGE;
                  end else if (!stat.tables_full) begin
                     cmd.alloc = 1'b1;
                     cmd.pg_rd = 1'b1;
                     state_in  = S_PAGE;
                  end else if (stat.out_free) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_NO_TABLE;
                     state_in   = S_IDLE;
                  end
               end
               OP_UNMAP: begin
                  if (stat.out_free) begin
                     cmd.finish      = 1'b1;
                     cmd.pg_unmap_wr = stat.dir_valid;
                     cmd.status      = stat.dir_valid ? ST_OK : ST_UNMAP_NO_TABLE;
                     state_in        = S_IDLE;
                  end
               end
               OP_XLATE: begin
                  if (stat.dir_valid) begin
                     cmd.pg_rd = 1'b1;
                     state_in  = S_PAGE;
                  end else if (stat.out_free) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_NOT_MAPPED;
                     state_in   = S_IDLE;
                  end
               end
               default: begin
                  if (stat.out_free) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_OK;
                     state_in   = S_IDLE;
                  end
               end
            endcase
         end
         S_PAGE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
               if (stat.op == OP_MAP) begin
                  cmd.pg_map_wr = !stat.pg_nonzero;
                  cmd.status    = stat.pg_nonzero ? ST_ALREADY : ST_OK;
               end else begin
                  cmd.xlate_ok = stat.pg_nonzero;
                  cmd.status   = stat.pg_nonzero ? ST_OK : ST_NOT_MAPPED;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// ===== hw/rtl/two_level_page_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_engine_top
// Two-level page table engine with 10/10/12 virtual address split.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation per item: map, unmap or translate.
//   rsp channel returns exactly one item per request: phys_result and
//   status, in request order.
//   An item passes these steps from accept to result when the rsp register is
//   free: accept and read the directory memory, check the directory entry
//   and read the page entry memory, then check the page entry and, for a map,
//   write it. The two dependent synchronous memory reads set these steps;
//   unmap, directory faults and table exhaustion end after the directory
//   check. A new item is accepted only once the previous one has finished.
//   After reset a clearing pass writes zero into both memories, one entry
//   a cycle, across every page entry; req_ready stays low meanwhile.
//   A stalled receiver holds the result in the rsp register; the engine
//   still accepts one more item and parks it at its last step until the
//   register frees up.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_top #(
   parameter int NUM_TABLES = ptw_pkg::NUM_TABLES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_opcode,
   input  logic [ptw_pkg::ADDR_W-1:0] req_virt_addr,
   input  logic [ptw_pkg::ADDR_W-1:0] req_phys_addr,
   input  logic [ptw_pkg::OFF_W-1:0]  req_page_flags,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ptw_pkg::ADDR_W-1:0] rsp_phys_result,
   output logic [2:0]                 rsp_status
);
   import ptw_pkg::*;

   ptw_cmd_type  cmd;
   ptw_stat_type stat;

   ptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptw_datapath #(
      .NUM_TABLES (NUM_TABLES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_virt_addr   (req_virt_addr),
      .req_phys_addr   (req_phys_addr),
      .req_page_flags  (req_page_flags),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_phys_result (rsp_phys_result),
      .rsp_status      (rsp_status)
   );

`ifndef SYNTHESIS
   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous item still in the walk");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_UNMAP_NO_TABLE)
      else $error("result status out of range");

   a_result_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_phys_result == '0)
      else $error("nonzero physical result on failed item");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ready)
      else $error("request taken before clearing pass");
`endif

endmodule
